// ----- rtl/core/message_fragmenter_top_macros.svh -----
// assertion macros for the message fragmenter
// used by message_fragmenter_top; no other dependencies
`ifndef MESSAGE_FRAGMENTER_TOP_MACROS_SVH
`define MESSAGE_FRAGMENTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// implication or plain property checked on every rising edge out of reset
`define MF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// condition that must never be true out of reset
`define MF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define MF_ASSERT(lbl, clk, rstn, prop, msg)
`define MF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- rtl/core/mf_pkg.sv -----
// package for the message fragmenter: sizes, header codes, state types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mf_pkg;

    localparam int PAYLOAD_BYTES = 32;
    localparam int STORE_DEPTH   = PAYLOAD_BYTES - 1;
    localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W         = $clog2(STORE_DEPTH + 1);
    localparam int CFG_W         = 5;
    localparam int BYTE_W        = 8;
    localparam int NUM_W         = 7;
    localparam int CFG_RESET     = 31;

    localparam logic [BYTE_W-1:0] LAST_FRAG_BIT = 8'h80;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_DAT
    } mf_state_t;

    typedef enum logic {
        MODE_FLUSH,
        MODE_FINAL
    } mf_mode_t;

    // size zero acts as one, sizes above the store are capped
    function automatic logic [CNT_W-1:0] effective_size(input logic [CFG_W-1:0] s);
        logic [CNT_W-1:0] r;
        if (s == '0) begin
            r = CNT_W'(1);
        end else if (32'(s) > STORE_DEPTH) begin
            r = CNT_W'(STORE_DEPTH);
        end else begin
            r = CNT_W'(s);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/message_fragmenter_top.sv -----
// Message fragmenter: takes message bytes (s_tdata) with an end-of-message flag
// (s_tlast) and sends radio packets of a header byte and up to frag_data_size
// data bytes. The header holds a 7-bit fragment index, with bit 7 set on the
// last fragment of a message. A full fragment is held in a 31-entry RAM until
// the next byte shows more data follows. A byte that sends nothing is stored
// with s_tready held high. A byte that sends a packet keeps s_tready low after
// its accept while the header byte and then each data byte, read from the
// single RAM read port, go out, and a flush followed by the final packet keeps
// it low through both packets; output back-pressure holds it low for longer.
// The RAM needs no clearing: only entries already written are read.
// depends on mf_pkg, mf_ram and message_fragmenter_top_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "message_fragmenter_top_macros.svh"

module message_fragmenter_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration: frag_data_size
    input  wire logic                          cfg_we,
    input  wire logic [mf_pkg::CFG_W-1:0]      cfg_wdata,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mf_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  wire logic                          s_tlast,   // end_of_message
    // packet stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [mf_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] packet_byte
    output logic                               m_tlast,   // last_of_packet
    output logic      [1:0]                    m_tuser    // [0] first_of_packet, [1] last_of_run
);

    import mf_pkg::*;

    mf_state_t         state_reg, state_next;
    mf_mode_t          mode_reg, mode_next;
    logic [CFG_W-1:0]  size_cfg_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              end_reg, end_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_first_reg, out_first_next;
    logic              out_lastp_reg, out_lastp_next;
    logic              out_lastr_reg, out_lastr_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic [CNT_W-1:0]  size_eff;
    logic              s_xfer;
    logic              slot_free;
    logic              need_flush;
    logic [ADDR_W-1:0] cnt_inc;
    logic              dat_last;

    // fragment store
    mf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and shared terms
    assign size_eff   = effective_size(size_cfg_reg);
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign slot_free  = !out_valid_reg || m_tready;
    assign need_flush = (fill_reg >= size_eff);
    assign cnt_inc    = cnt_reg + ADDR_W'(1);
    assign dat_last   = ((CNT_W'(cnt_reg) + CNT_W'(1)) == fill_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (need_flush || s_tlast)) begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                if (slot_free) begin
                    state_next = ST_DAT;
                end
            end
            ST_DAT: begin
                if (slot_free && dat_last) begin
                    if (mode_reg == MODE_FLUSH && end_reg) begin
                        state_next = ST_HDR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        mode_next      = mode_reg;
        fill_next      = fill_reg;
        num_next       = num_reg;
        cnt_next       = cnt_reg;
        byte_next      = byte_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_first_next = out_first_reg;
        out_lastp_next = out_lastp_reg;
        out_lastr_next = out_lastr_reg;
        ram_we         = 1'b0;
        ram_waddr      = fill_reg[ADDR_W-1:0];
        ram_wdata      = s_tdata;
        ram_re         = 1'b0;
        ram_raddr      = cnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    byte_next = s_tdata;
                    end_next  = s_tlast;
                    if (need_flush) begin
                        // held bytes go out before the new byte is stored
                        mode_next = MODE_FLUSH;
                    end else begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                        mode_next = MODE_FINAL;
                    end
                end
            end
            ST_HDR: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = (mode_reg == MODE_FINAL) ?
                                     (LAST_FRAG_BIT | BYTE_W'(num_reg)) : BYTE_W'(num_reg);
                    out_first_next = 1'b1;
                    out_lastp_next = (fill_reg == '0);
                    out_lastr_next = (fill_reg == '0) &&
                                     (mode_reg == MODE_FINAL || !end_reg);
                    // fetch the first data byte
                    ram_re   = 1'b1;
                    ram_raddr = '0;
                    cnt_next = '0;
                end
            end
            ST_DAT: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_first_next = 1'b0;
                    out_lastp_next = dat_last;
                    out_lastr_next = dat_last && (mode_reg == MODE_FINAL || !end_reg);
                    if (!dat_last) begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_inc;
                        cnt_next  = cnt_inc;
                    end else if (mode_reg == MODE_FLUSH) begin
                        // packet done, store the pending byte at the start
                        num_next  = num_reg + NUM_W'(1);
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = byte_reg;
                        fill_next = CNT_W'(1);
                        mode_next = MODE_FINAL;
                    end else begin
                        num_next  = '0;
                        fill_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_FINAL;
            size_cfg_reg  <= CFG_W'(CFG_RESET);
            fill_reg      <= '0;
            num_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            fill_reg      <= fill_next;
            num_reg       <= num_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                size_cfg_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        byte_reg      <= byte_next;
        end_reg       <= end_next;
        out_byte_reg  <= out_byte_next;
        out_first_reg <= out_first_next;
        out_lastp_reg <= out_lastp_next;
        out_lastr_reg <= out_lastr_next;
    end

    // output transfer
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_lastp_reg;
    assign m_tuser[0] = out_first_reg;
    assign m_tuser[1] = out_lastr_reg;

    // reads stay below the fill level
    `MF_ASSERT(a_read_in_fill, aclk, aresetn,
        (state_reg == ST_DAT) |-> (CNT_W'(cnt_reg) < fill_reg),
        "data read beyond fill level")
    // a byte that sends nothing just adds one to the fill level
    `MF_ASSERT(a_fill_step, aclk, aresetn,
        (s_xfer && !need_flush && !s_tlast) |=>
            (fill_reg == $past(fill_reg) + CNT_W'(1)) && (state_reg == ST_IDLE),
        "fill level not advanced by a stored byte")
    // closing a message clears index and fill level
    `MF_ASSERT(a_final_clears, aclk, aresetn,
        (state_reg == ST_DAT && mode_reg == MODE_FINAL && slot_free && dat_last) |=>
            (num_reg == '0) && (fill_reg == '0),
        "final packet did not reset fragment state")
    // read and write never meet at one entry
    `MF_ASSERT_NEVER(a_ram_collide, aclk, aresetn,
        ram_we && ram_re && (ram_waddr == ram_raddr),
        "store read and write at the same entry")

endmodule

`default_nettype wire

// ----- rtl/core/mf_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sim/message_fragmenter_top_test.sv -----
// testbench for message_fragmenter_top: drives message bytes with random gaps and
// output stalls, predicts every packet byte and checks each m_ transfer against it
// depends on mf_pkg and message_fragmenter_top
`timescale 1ns / 1ps

module message_fragmenter_top_test;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 12;

    // one expected byte on the packet stream
    typedef struct packed {
        logic [mf_pkg::BYTE_W-1:0] pbyte;
        logic                      first;
        logic                      last_pkt;
        logic                      last_run;
    } packet_byte_t;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [mf_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [mf_pkg::BYTE_W-1:0]   s_tdata   = '0;   // [7:0] data_byte
    logic                        s_tlast   = 1'b0; // end_of_message
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [mf_pkg::BYTE_W-1:0]   m_tdata;          // [7:0] packet_byte
    logic                        m_tlast;          // last_of_packet
    logic [1:0]                  m_tuser;          // [0] first_of_packet, [1] last_of_run

    // predicted fragmenter state
    logic [mf_pkg::BYTE_W-1:0]   frag_store [mf_pkg::STORE_DEPTH];
    int                          frag_fill  = 0;
    logic [mf_pkg::NUM_W-1:0]    pred_index = '0;
    logic [mf_pkg::CFG_W-1:0]    pred_size  = mf_pkg::CFG_RESET;

    packet_byte_t                expected_packet_bytes [$];
    int                          error_count = 0;
    int                          cycle_count = 0;
    int                          ready_stall = 0;
    bit                          quiet       = 1'b0;

    message_fragmenter_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while quiet
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // sizes weighted toward the extremes and small fragments
    function automatic logic [mf_pkg::CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd31;
            3: return 5'd30;
            4: return 5'd2;
            default: return mf_pkg::CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // output back-pressure
    always @(posedge aclk) begin
        if (ready_stall > 0) begin
            m_tready    <= 1'b0;
            ready_stall <= ready_stall - 1;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                ready_stall <= pick_gap();
            end
        end
    end

    // queue one packet: header, then every held byte
    function automatic void queue_packet(input logic [mf_pkg::BYTE_W-1:0] header);
        packet_byte_t b;
        int n;
        n = frag_fill;
        b.pbyte    = header;
        b.first    = 1'b1;
        b.last_pkt = (n == 0);
        b.last_run = 1'b0;
        expected_packet_bytes.push_back(b);
        for (int i = 0; i < n; i++) begin
            b.pbyte    = frag_store[i];
            b.first    = 1'b0;
            b.last_pkt = (i == n - 1);
            expected_packet_bytes.push_back(b);
        end
        frag_fill = 0;
    endfunction

    // expected packet bytes caused by one accepted message byte
    function automatic void predict_packets(input logic [mf_pkg::BYTE_W-1:0] data,
                                            input logic eom);
        int eff;
        int queued;
        packet_byte_t b;
        queued = expected_packet_bytes.size();
        eff = (pred_size == '0) ? 1 : int'(pred_size);
        if (eff > mf_pkg::STORE_DEPTH) eff = mf_pkg::STORE_DEPTH;
        // a full fragment is proven non-last by this byte
        if (frag_fill >= eff) begin
            queue_packet({1'b0, pred_index});
            pred_index = pred_index + 1'b1;
        end
        if (frag_fill < mf_pkg::STORE_DEPTH) begin
            frag_store[frag_fill] = data;
            frag_fill++;
        end
        if (eom) begin
            queue_packet(mf_pkg::LAST_FRAG_BIT | {1'b0, pred_index});
            pred_index = '0;
        end
        if (expected_packet_bytes.size() > queued) begin
            b = expected_packet_bytes.pop_back();
            b.last_run = 1'b1;
            expected_packet_bytes.push_back(b);
        end
    endfunction

    // packet stream checker
    always @(posedge aclk) begin : packet_check
        packet_byte_t exp_b;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_packet_bytes.size() == 0) begin
                $error("unexpected packet byte transfer: data %h", m_tdata);
                error_count++;
            end else begin
                exp_b = expected_packet_bytes.pop_front();
                if (m_tdata !== exp_b.pbyte) begin
                    $error("packet_byte: expected %h, got %h", exp_b.pbyte, m_tdata);
                    error_count++;
                end
                if (m_tuser[0] !== exp_b.first) begin
                    $error("first_of_packet: expected %b, got %b", exp_b.first, m_tuser[0]);
                    error_count++;
                end
                if (m_tlast !== exp_b.last_pkt) begin
                    $error("last_of_packet: expected %b, got %b", exp_b.last_pkt, m_tlast);
                    error_count++;
                end
                if (m_tuser[1] !== exp_b.last_run) begin
                    $error("last_of_run: expected %b, got %b", exp_b.last_run, m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    // one message byte on the input stream
    task automatic send_message_byte(input logic [mf_pkg::BYTE_W-1:0] data,
                                     input logic eom);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        predict_packets(data, eom);
    endtask

    // stop sending and let every expected packet byte come out
    task automatic wait_packets_drained();
        s_tvalid <= 1'b0;
        while (expected_packet_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_fragment_size(input logic [mf_pkg::CFG_W-1:0] size);
        wait_packets_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pred_size = size;
    endtask

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_message_byte(mf_pkg::BYTE_W'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // reset size, short message and a one-byte message
    task automatic test_default_size();
        send_message_byte(8'h00, 1'b0);
        send_message_byte(8'hFF, 1'b0);
        send_message_byte(8'h5A, 1'b1);
        send_message_byte(8'hA5, 1'b1);
        wait_packets_drained();
    endtask

    // size zero behaves as one byte per packet
    task automatic test_size_zero();
        set_fragment_size(5'd0);
        send_message_byte(8'hFF, 1'b0);
        send_message_byte(8'h00, 1'b0);
        send_message_byte(8'h81, 1'b1);
        wait_packets_drained();
    endtask

    // messages ending exactly on a full fragment
    task automatic test_exact_fill();
        set_fragment_size(5'd2);
        send_message_byte(8'h11, 1'b0);
        send_message_byte(8'h22, 1'b1);
        send_message_byte(8'h33, 1'b0);
        send_message_byte(8'h44, 1'b0);
        send_message_byte(8'h55, 1'b0);
        send_message_byte(8'h66, 1'b1);
        wait_packets_drained();
    endtask

    // size lowered below the bytes already held
    task automatic test_size_lowered();
        set_fragment_size(5'd8);
        send_message_byte(8'h01, 1'b0);
        send_message_byte(8'h80, 1'b0);
        send_message_byte(8'h7F, 1'b0);
        send_message_byte(8'hFE, 1'b0);
        send_message_byte(8'h2C, 1'b0);
        set_fragment_size(5'd2);
        send_message_byte(8'hC3, 1'b1);
        wait_packets_drained();
    endtask

    // fragment index wraps past 127 within one message, with gaps and stalls
    task automatic test_index_wrap();
        set_fragment_size(5'd1);
        send_random_message(129);
        wait_packets_drained();
    endtask

    // random messages, sizes changed between and inside messages
    task automatic test_random_messages();
        int items;
        int eff;
        int len;
        items = 0;
        while (items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) set_fragment_size(pick_size());
            quiet = ($urandom_range(0, 4) == 0);
            eff = (pred_size == '0) ? 1 : int'(pred_size);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 70)
                                              : $urandom_range(1, 2 * eff + 2);
            if (len > RANDOM_ITEMS - items) len = RANDOM_ITEMS - items;
            for (int i = 0; i < len; i++) begin
                // sender pause, sometimes with a new size mid-message
                if (i > 0 && $urandom_range(0, 39) == 0) begin
                    wait_packets_drained();
                    if ($urandom_range(0, 1) == 1) set_fragment_size(pick_size());
                end
                send_message_byte(mf_pkg::BYTE_W'($urandom_range(0, 255)), i == len - 1);
                items++;
            end
        end
        quiet = 1'b0;
        wait_packets_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_size();
        test_size_zero();
        test_exact_fill();
        test_size_lowered();
        test_index_wrap();
        test_random_messages();
        set_fragment_size(5'd31);
        send_random_message(32);
        wait_packets_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/mf_pkg.sv
rtl/core/mf_ram.sv
rtl/core/message_fragmenter_top.sv
sim/message_fragmenter_top_test.sv
